FILE: hdl/sfc_pkg.sv
// Shared types, codes and constants of the serial frame checker.
package sfc_pkg;

	localparam int SFC_MAX_PAYLOAD = 32;

	typedef logic [7:0] byte_t;

	// frame kind tag on each received byte
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_CMD  = 2'd0;
	localparam kind_t KIND_DATA = 2'd1;
	localparam kind_t KIND_ACK  = 2'd2;

	// frame verdict reported with each byte
	typedef logic [1:0] status_t;
	localparam status_t ST_BUSY   = 2'd0;
	localparam status_t ST_ACCEPT = 2'd1;
	localparam status_t ST_REJECT = 2'd2;

	// configuration register indexes
	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_HDR_BYTE       = 3'd0;
	localparam reg_idx_t REG_MAIN_DEVICE_ID = 3'd1;
	localparam reg_idx_t REG_COPY_DEVICE_ID = 3'd2;
	localparam reg_idx_t REG_TAIL_BYTE      = 3'd3;
	localparam reg_idx_t REG_DATA_FUNC_CODE = 3'd4;
	localparam reg_idx_t REG_ACK_HDR_BYTE   = 3'd5;
	localparam reg_idx_t REG_ACK_ID_BYTE    = 3'd6;
	localparam reg_idx_t REG_ACK_MARKER     = 3'd7;

	localparam byte_t RST_HDR_BYTE       = 8'hA5;
	localparam byte_t RST_MAIN_DEVICE_ID = 8'h01;
	localparam byte_t RST_COPY_DEVICE_ID = 8'h02;
	localparam byte_t RST_TAIL_BYTE      = 8'hFE;
	localparam byte_t RST_DATA_FUNC_CODE = 8'h0F;
	localparam byte_t RST_ACK_HDR_BYTE   = 8'h5A;
	localparam byte_t RST_ACK_ID_BYTE    = 8'h10;
	localparam byte_t RST_ACK_MARKER     = 8'hFF;

	localparam int COUNT_W = 6;
	localparam int SLOT_W  = 5;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_CMD,
		PH_DATA,
		PH_ACK
	} phase_t;

	typedef enum logic [1:0] {
		GO_ON,
		GO_ACCEPT,
		GO_REJECT
	} go_t;

	typedef struct packed {
		byte_t hdr_byte;
		byte_t main_device_id;
		byte_t copy_device_id;
		byte_t tail_byte;
		byte_t data_func_code;
		byte_t ack_hdr_byte;
		byte_t ack_id_byte;
		byte_t ack_marker;
	} cfg_regs_t;

	typedef struct packed {
		status_t             frame_status;
		byte_t               cmd_code;
		byte_t               function_code;
		logic [COUNT_W-1:0]  payload_count;
		byte_t               payload_value;
		logic [SLOT_W-1:0]   payload_slot;
		logic                payload_strobe;
	} result_t;

endpackage

FILE: hdl/sfc_if.sv
// Channel interfaces: received bytes, frame results and register writes.
interface sfc_rx_if import sfc_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t rx_byte;
	kind_t req_type;
	logic  buffer_last;

	modport source (output valid, rx_byte, req_type, buffer_last, input ready);
	modport sink (input valid, rx_byte, req_type, buffer_last, output ready);
endinterface

interface sfc_res_if import sfc_pkg::*; ();
	logic                valid;
	logic                ready;
	status_t             frame_status;
	byte_t               cmd_code;
	byte_t               function_code;
	logic [COUNT_W-1:0]  payload_count;
	byte_t               payload_value;
	logic [SLOT_W-1:0]   payload_slot;
	logic                payload_strobe;

	modport source (output valid, frame_status, cmd_code, function_code, payload_count,
		payload_value, payload_slot, payload_strobe, input ready);
	modport sink (input valid, frame_status, cmd_code, function_code, payload_count,
		payload_value, payload_slot, payload_strobe, output ready);
endinterface

interface sfc_cfg_if import sfc_pkg::*; ();
	logic     valid;
	logic     ready;
	reg_idx_t index;
	byte_t    wdata;

	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

FILE: hdl/sfc_cfg_regs.sv
// Configuration register file: frame marker and identifier bytes.
module sfc_cfg_regs import sfc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sfc_cfg_if.sink   cfg,
	output cfg_regs_t regs
);

	cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.hdr_byte       <= RST_HDR_BYTE;
			regs_q.main_device_id <= RST_MAIN_DEVICE_ID;
			regs_q.copy_device_id <= RST_COPY_DEVICE_ID;
			regs_q.tail_byte      <= RST_TAIL_BYTE;
			regs_q.data_func_code <= RST_DATA_FUNC_CODE;
			regs_q.ack_hdr_byte   <= RST_ACK_HDR_BYTE;
			regs_q.ack_id_byte    <= RST_ACK_ID_BYTE;
			regs_q.ack_marker     <= RST_ACK_MARKER;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_HDR_BYTE:       regs_q.hdr_byte       <= cfg.wdata;
				REG_MAIN_DEVICE_ID: regs_q.main_device_id <= cfg.wdata;
				REG_COPY_DEVICE_ID: regs_q.copy_device_id <= cfg.wdata;
				REG_TAIL_BYTE:      regs_q.tail_byte      <= cfg.wdata;
				REG_DATA_FUNC_CODE: regs_q.data_func_code <= cfg.wdata;
				REG_ACK_HDR_BYTE:   regs_q.ack_hdr_byte   <= cfg.wdata;
				REG_ACK_ID_BYTE:    regs_q.ack_id_byte    <= cfg.wdata;
				REG_ACK_MARKER:     regs_q.ack_marker     <= cfg.wdata;
				default: ;
			endcase
		end
	end

endmodule

FILE: hdl/sfc_parser.sv
// Frame parse state machine: per-byte checks, running BCC and held fields.
module sfc_parser import sfc_pkg::*; #(
	parameter int MAX_PAYLOAD = SFC_MAX_PAYLOAD
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  byte_t     rx_byte,
	input  kind_t     req_type,
	input  logic      buffer_last,
	input  cfg_regs_t regs,
	output result_t   result
);

	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
	localparam int POS_W = $clog2(MAX_PAYLOAD + 7);

	phase_t           phase_q, phase_d;
	logic [POS_W-1:0] pos_q, pos_d;
	byte_t            xor_q, xor_d;
	byte_t            cmd_q, cmd_d;
	byte_t            func_q, func_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic             discard_q, discard_d;

	go_t              go;
	logic             is_tail, is_final, strobe;
	logic             clear_held, load_cmd, load_func, load_len, hdr_ok;
	logic [POS_W-1:0] pay_end;

	assign pay_end = POS_W'(5) + POS_W'(len_q);

	// per-byte checks
	always_comb begin
		go         = GO_ON;
		is_tail    = 1'b0;
		is_final   = 1'b0;
		strobe     = 1'b0;
		clear_held = 1'b0;
		load_cmd   = 1'b0;
		load_func  = 1'b0;
		load_len   = 1'b0;
		hdr_ok     = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				clear_held = 1'b1;
				if (req_type == KIND_CMD || req_type == KIND_DATA)
					hdr_ok = (rx_byte == regs.hdr_byte);
				else if (req_type == KIND_ACK)
					hdr_ok = (rx_byte == regs.ack_hdr_byte);
				if (!hdr_ok)
					go = GO_REJECT;
			end
			PH_CMD: begin
				if (pos_q == POS_W'(1)) begin
					if (rx_byte != regs.main_device_id && rx_byte != regs.copy_device_id)
						go = GO_REJECT;
				end else if (pos_q == POS_W'(2)) begin
					load_cmd = 1'b1;
				end else if (pos_q == POS_W'(3)) begin
					load_func = 1'b1;
				end else if (pos_q == POS_W'(4)) begin
					is_tail = 1'b1;
					if (rx_byte != regs.tail_byte)
						go = GO_REJECT;
				end else begin
					is_final = 1'b1;
					go = (buffer_last && rx_byte == xor_q) ? GO_ACCEPT : GO_REJECT;
				end
			end
			PH_ACK: begin
				if (pos_q == POS_W'(1)) begin
					if (rx_byte != regs.ack_id_byte)
						go = GO_REJECT;
				end else if (pos_q == POS_W'(2)) begin
					if (rx_byte != regs.ack_marker)
						go = GO_REJECT;
				end else if (pos_q == POS_W'(3)) begin
					load_cmd = 1'b1;
				end else if (pos_q == POS_W'(4)) begin
					load_func = 1'b1;
				end else if (pos_q == POS_W'(5)) begin
					is_tail = 1'b1;
					if (rx_byte != regs.tail_byte)
						go = GO_REJECT;
				end else begin
					is_final = 1'b1;
					go = (buffer_last && rx_byte == xor_q) ? GO_ACCEPT : GO_REJECT;
				end
			end
			default: begin
				if (pos_q == POS_W'(1)) begin
					if (rx_byte != regs.main_device_id)
						go = GO_REJECT;
				end else if (pos_q == POS_W'(2)) begin
					load_cmd = 1'b1;
				end else if (pos_q == POS_W'(3)) begin
					load_func = 1'b1;
					if (rx_byte != regs.data_func_code)
						go = GO_REJECT;
				end else if (pos_q == POS_W'(4)) begin
					if ({1'b0, rx_byte} > 9'(MAX_PAYLOAD))
						go = GO_REJECT;
					else
						load_len = 1'b1;
				end else if (pos_q < pay_end) begin
					strobe = 1'b1;
				end else if (pos_q == pay_end) begin
					is_tail = 1'b1;
					if (rx_byte != regs.tail_byte)
						go = GO_REJECT;
				end else begin
					// trailing bytes after the BCC are dropped, so no last check here
					is_final = 1'b1;
					go = (rx_byte == xor_q) ? GO_ACCEPT : GO_REJECT;
				end
			end
		endcase
		if (go == GO_ON && !is_final && buffer_last)
			go = GO_REJECT;
	end

	// next state
	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		xor_d     = xor_q;
		cmd_d     = cmd_q;
		func_d    = func_q;
		len_d     = len_q;
		discard_d = discard_q;
		if (discard_q) begin
			if (buffer_last)
				discard_d = 1'b0;
		end else begin
			if (clear_held) begin
				cmd_d  = '0;
				func_d = '0;
				len_d  = '0;
			end
			if (load_cmd)
				cmd_d = rx_byte;
			if (load_func)
				func_d = rx_byte;
			if (load_len)
				len_d = LEN_W'(rx_byte);
			if (go == GO_ON) begin
				if (phase_q == PH_IDLE) begin
					xor_d = rx_byte;
					pos_d = POS_W'(1);
					case (req_type)
						KIND_CMD:  phase_d = PH_CMD;
						KIND_DATA: phase_d = PH_DATA;
						default:   phase_d = PH_ACK;
					endcase
				end else begin
					if (!is_tail)
						xor_d = xor_q ^ rx_byte;
					pos_d = pos_q + POS_W'(1);
				end
			end else begin
				phase_d   = PH_IDLE;
				pos_d     = '0;
				xor_d     = '0;
				discard_d = !buffer_last;
			end
		end
	end

	// result for this byte
	always_comb begin
		result                = '0;
		result.cmd_code       = cmd_d;
		result.function_code  = func_d;
		result.payload_count  = COUNT_W'(len_d);
		if (!discard_q) begin
			case (go)
				GO_ACCEPT: result.frame_status = ST_ACCEPT;
				GO_REJECT: result.frame_status = ST_REJECT;
				default:   result.frame_status = ST_BUSY;
			endcase
			if (strobe) begin
				result.payload_strobe = 1'b1;
				result.payload_value  = rx_byte;
				result.payload_slot   = SLOT_W'(pos_q - POS_W'(5));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			pos_q     <= '0;
			xor_q     <= '0;
			cmd_q     <= '0;
			func_q    <= '0;
			len_q     <= '0;
			discard_q <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			xor_q     <= xor_d;
			cmd_q     <= cmd_d;
			func_q    <= func_d;
			len_q     <= len_d;
			discard_q <= discard_d;
		end
	end

endmodule

FILE: hdl/serial_frame_checker_bcc_core.sv
// Top level of the serial frame checker with BCC.
// Checks command, data and acknowledge frames one received byte per request and
// returns one result per byte. Each byte is registered on entry, checked against the
// parse state combinationally, and its result is registered for output, so a byte
// passes through the input register and then the result register, and a new byte
// can be taken every cycle while the output is not stalled. While a result waits
// at the output, one more byte is still taken into the input register.
// Payload bytes are passed on as they arrive, before the frame verdict on its BCC byte.
module serial_frame_checker_bcc_core import sfc_pkg::*; #(
	parameter int MAX_PAYLOAD = SFC_MAX_PAYLOAD
) (
	input  logic      clk,
	input  logic      arst_n,
	sfc_rx_if.sink    rx,
	sfc_res_if.source verdict,
	sfc_cfg_if.sink   cfg
);

	cfg_regs_t regs;
	result_t   result;
	result_t   result_q;
	logic      res_valid_q;
	logic      valid_s1;
	byte_t     byte_s1;
	kind_t     kind_s1;
	logic      last_s1;
	logic      advance;

	assign advance  = !res_valid_q || verdict.ready;
	assign rx.ready = !valid_s1 || advance;

	sfc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	sfc_parser #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (valid_s1 && advance),
		.rx_byte     (byte_s1),
		.req_type    (kind_s1),
		.buffer_last (last_s1),
		.regs        (regs),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (rx.ready)
				valid_s1 <= rx.valid;
			if (advance)
				res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
			kind_s1 <= rx.req_type;
			last_s1 <= rx.buffer_last;
		end
		if (valid_s1 && advance)
			result_q <= result;
	end

	assign verdict.valid          = res_valid_q;
	assign verdict.frame_status   = result_q.frame_status;
	assign verdict.cmd_code       = result_q.cmd_code;
	assign verdict.function_code  = result_q.function_code;
	assign verdict.payload_count  = result_q.payload_count;
	assign verdict.payload_value  = result_q.payload_value;
	assign verdict.payload_slot   = result_q.payload_slot;
	assign verdict.payload_strobe = result_q.payload_strobe;

endmodule

FILE: hdl/sfc_checker.sv
// Port-level assertions for the frame checker, bound to the top level.
module sfc_checker import sfc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input status_t            frame_status,
	input logic [COUNT_W-1:0] payload_count,
	input byte_t              payload_value,
	input logic [SLOT_W-1:0]  payload_slot,
	input logic               payload_strobe
);

	// a stalled result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// a payload byte never closes a frame as accepted (a short buffer may reject it)
	a_pay_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && payload_strobe |-> frame_status != ST_ACCEPT)
		else $error("payload byte carried an accept");

	// no payload byte: value and slot read zero
	a_pay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !payload_strobe |-> payload_value == 8'h00 && payload_slot == '0)
		else $error("payload fields set without strobe");

	// a payload slot lies inside the declared length
	a_pay_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && payload_strobe && payload_count <= COUNT_W'(32)
		|-> COUNT_W'(payload_slot) < payload_count)
		else $error("payload slot beyond declared length");

endmodule

bind serial_frame_checker_bcc_core sfc_checker u_sfc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (verdict.valid),
	.res_ready      (verdict.ready),
	.frame_status   (verdict.frame_status),
	.payload_count  (verdict.payload_count),
	.payload_value  (verdict.payload_value),
	.payload_slot   (verdict.payload_slot),
	.payload_strobe (verdict.payload_strobe)
);

FILE: tb/serial_frame_checker_bcc_checker.sv
// Checker for the serial frame checker: predicts each byte's result and compares it.
module serial_frame_checker_bcc_checker import sfc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	sfc_rx_if    rx,
	sfc_res_if   verdict,
	sfc_cfg_if   cfg,
	output int   errors,
	output int   pending
);
	localparam int REPORT_MAX = 10;

	cfg_regs_t regs;
	phase_t    phase;
	int        pos;
	byte_t     bcc;
	byte_t     held_cmd;
	byte_t     held_fn;
	byte_t     held_len;
	logic      skipping;
	result_t   due_verdicts[$];

	// Parses one received byte against the current frame state.
	function automatic result_t judge_byte(byte_t b, kind_t k, logic last);
		result_t r;
		go_t     go;
		logic    at_tail;
		logic    at_bcc;
		int      p;
		r = '0;
		go = GO_ON;
		at_tail = 1'b0;
		at_bcc = 1'b0;
		p = pos;
		if (skipping) begin
			if (last)
				skipping = 1'b0;
		end else begin
			case (phase)
			PH_IDLE: begin
				held_cmd = '0;
				held_fn = '0;
				held_len = '0;
				bcc = '0;
				p = 0;
				if ((k == KIND_CMD || k == KIND_DATA) && b == regs.hdr_byte)
					phase = (k == KIND_CMD) ? PH_CMD : PH_DATA;
				else if (k == KIND_ACK && b == regs.ack_hdr_byte)
					phase = PH_ACK;
				else
					go = GO_REJECT;
			end
			PH_CMD: begin
				if (p == 1) begin
					if (b != regs.main_device_id && b != regs.copy_device_id)
						go = GO_REJECT;
				end else if (p == 2) begin
					held_cmd = b;
				end else if (p == 3) begin
					held_fn = b;
				end else if (p == 4) begin
					at_tail = 1'b1;
					if (b != regs.tail_byte)
						go = GO_REJECT;
				end else begin
					at_bcc = 1'b1;
					go = (last && b == bcc) ? GO_ACCEPT : GO_REJECT;
				end
			end
			PH_ACK: begin
				if (p == 1) begin
					if (b != regs.ack_id_byte)
						go = GO_REJECT;
				end else if (p == 2) begin
					if (b != regs.ack_marker)
						go = GO_REJECT;
				end else if (p == 3) begin
					held_cmd = b;
				end else if (p == 4) begin
					held_fn = b;
				end else if (p == 5) begin
					at_tail = 1'b1;
					if (b != regs.tail_byte)
						go = GO_REJECT;
				end else begin
					at_bcc = 1'b1;
					go = (last && b == bcc) ? GO_ACCEPT : GO_REJECT;
				end
			end
			default: begin
				if (p == 1) begin
					if (b != regs.main_device_id)
						go = GO_REJECT;
				end else if (p == 2) begin
					held_cmd = b;
				end else if (p == 3) begin
					held_fn = b;
					if (b != regs.data_func_code)
						go = GO_REJECT;
				end else if (p == 4) begin
					if (b > SFC_MAX_PAYLOAD)
						go = GO_REJECT;
					else
						held_len = b;
				end else if (p < 5 + held_len) begin
					r.payload_strobe = 1'b1;
					r.payload_value = b;
					r.payload_slot = SLOT_W'(p - 5);
				end else if (p == 5 + held_len) begin
					at_tail = 1'b1;
					if (b != regs.tail_byte)
						go = GO_REJECT;
				end else begin
					// data frames take trailing bytes, so last is not required here
					at_bcc = 1'b1;
					go = (b == bcc) ? GO_ACCEPT : GO_REJECT;
				end
			end
			endcase

			if (go == GO_ON && !at_bcc && last)
				go = GO_REJECT;

			if (go == GO_ON) begin
				if (!at_tail)
					bcc ^= b;
				pos = p + 1;
			end else begin
				r.frame_status = (go == GO_ACCEPT) ? ST_ACCEPT : ST_REJECT;
				phase = PH_IDLE;
				pos = 0;
				bcc = '0;
				skipping = !last;
			end
		end
		r.cmd_code = held_cmd;
		r.function_code = held_fn;
		r.payload_count = held_len[COUNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			regs = '{RST_HDR_BYTE, RST_MAIN_DEVICE_ID, RST_COPY_DEVICE_ID,
				RST_TAIL_BYTE, RST_DATA_FUNC_CODE, RST_ACK_HDR_BYTE,
				RST_ACK_ID_BYTE, RST_ACK_MARKER};
			phase = PH_IDLE;
			pos = 0;
			bcc = '0;
			held_cmd = '0;
			held_fn = '0;
			held_len = '0;
			skipping = 1'b0;
			due_verdicts.delete();
			errors = 0;
		end else begin
			// results first: a byte taken at this edge cannot have its result out yet
			if (verdict.valid && verdict.ready) begin
				got.frame_status = verdict.frame_status;
				got.cmd_code = verdict.cmd_code;
				got.function_code = verdict.function_code;
				got.payload_count = verdict.payload_count;
				got.payload_value = verdict.payload_value;
				got.payload_slot = verdict.payload_slot;
				got.payload_strobe = verdict.payload_strobe;
				if (due_verdicts.size() == 0) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display("unexpected result %h with nothing pending", got);
				end else begin
					want = due_verdicts.pop_front();
					if (got.frame_status !== want.frame_status ||
						got.cmd_code !== want.cmd_code ||
						got.function_code !== want.function_code ||
						got.payload_count !== want.payload_count ||
						got.payload_value !== want.payload_value ||
						got.payload_slot !== want.payload_slot ||
						got.payload_strobe !== want.payload_strobe) begin
						errors++;
						if (errors <= REPORT_MAX)
							$display({"mismatch (expected/actual): status %0d/%0d cmd %h/%h",
								" func %h/%h count %0d/%0d value %h/%h slot %0d/%0d",
								" strobe %b/%b"},
								want.frame_status, got.frame_status,
								want.cmd_code, got.cmd_code,
								want.function_code, got.function_code,
								want.payload_count, got.payload_count,
								want.payload_value, got.payload_value,
								want.payload_slot, got.payload_slot,
								want.payload_strobe, got.payload_strobe);
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
				REG_HDR_BYTE:       regs.hdr_byte = cfg.wdata;
				REG_MAIN_DEVICE_ID: regs.main_device_id = cfg.wdata;
				REG_COPY_DEVICE_ID: regs.copy_device_id = cfg.wdata;
				REG_TAIL_BYTE:      regs.tail_byte = cfg.wdata;
				REG_DATA_FUNC_CODE: regs.data_func_code = cfg.wdata;
				REG_ACK_HDR_BYTE:   regs.ack_hdr_byte = cfg.wdata;
				REG_ACK_ID_BYTE:    regs.ack_id_byte = cfg.wdata;
				REG_ACK_MARKER:     regs.ack_marker = cfg.wdata;
				default: ;
				endcase
			end
			if (rx.valid && rx.ready)
				due_verdicts.push_back(judge_byte(rx.rx_byte, rx.req_type, rx.buffer_last));
		end
		pending = due_verdicts.size();
	end

endmodule

FILE: tb/serial_frame_checker_bcc_core_tb.sv
// Testbench top: clock, reset, byte and register stimulus, and the final verdict.
module serial_frame_checker_bcc_core_tb import sfc_pkg::*; ();
	localparam int    QUIET_LIMIT = 4000;
	localparam int    PHASE_BYTES = 145;
	localparam kind_t KIND_BAD    = 2'd3;

	logic      clk;
	logic      arst_n;
	logic      calm;
	int        errors;
	int        pending;
	int        bytes_sent;
	int        quiet_cycles;
	cfg_regs_t live;

	sfc_rx_if  rx ();
	sfc_res_if verdict ();
	sfc_cfg_if cfg ();

	serial_frame_checker_bcc_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.verdict (verdict),
		.cfg     (cfg)
	);

	serial_frame_checker_bcc_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.verdict (verdict),
		.cfg     (cfg),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk)
		verdict.ready <= calm || ($urandom_range(0, 99) >= 25);

	// no request moving on any channel for too long means a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx.valid && rx.ready) || (verdict.valid && verdict.ready) ||
				(cfg.valid && cfg.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no request moved for %0d cycles", quiet_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic send_byte(input byte_t b, input kind_t k, input logic last);
		while (!calm && $urandom_range(0, 99) < 25) begin
			rx.valid <= 1'b0;
			@(posedge clk);
		end
		rx.valid       <= 1'b1;
		rx.rx_byte     <= b;
		rx.req_type    <= k;
		rx.buffer_last <= last;
		do @(posedge clk); while (!rx.ready);
		bytes_sent++;
	endtask

	// kind only counts on the first byte; later bytes carry random kinds
	task automatic send_seq(input byte_t q[$], input kind_t k);
		for (int i = 0; i < q.size(); i++)
			send_byte(q[i], (i == 0) ? k : kind_t'($urandom_range(0, 3)), i == q.size() - 1);
	endtask

	task automatic seal(ref byte_t q[$]);
		byte_t x;
		x = '0;
		foreach (q[i])
			x ^= q[i];
		q.push_back(live.tail_byte);
		q.push_back(x);
	endtask

	task automatic drain();
		rx.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_regs(input cfg_regs_t v);
		byte_t vals[8];
		vals = '{v.hdr_byte, v.main_device_id, v.copy_device_id, v.tail_byte,
			v.data_func_code, v.ack_hdr_byte, v.ack_id_byte, v.ack_marker};
		for (int i = 0; i < 8; i++) begin
			cfg.valid <= 1'b1;
			cfg.index <= reg_idx_t'(i);
			cfg.wdata <= vals[i];
			do @(posedge clk); while (!cfg.ready);
		end
		cfg.valid <= 1'b0;
		live = v;
	endtask

	task automatic send_random_buffer();
		byte_t q[$];
		kind_t k;
		int    pick;
		int    sel;
		int    len;
		int    spot;
		pick = $urandom_range(0, 99);
		k = kind_t'($urandom_range(0, 2));
		if (pick < 12) begin
			repeat ($urandom_range(1, 8))
				q.push_back(8'($urandom));
			send_seq(q, kind_t'($urandom_range(0, 3)));
		end else begin
			case (k)
			KIND_CMD: begin
				q.push_back(live.hdr_byte);
				q.push_back($urandom_range(0, 1) ? live.main_device_id : live.copy_device_id);
				q.push_back(8'($urandom));
				q.push_back(8'($urandom));
			end
			KIND_ACK: begin
				q.push_back(live.ack_hdr_byte);
				q.push_back(live.ack_id_byte);
				q.push_back(live.ack_marker);
				q.push_back(8'($urandom));
				q.push_back(8'($urandom));
			end
			default: begin
				sel = $urandom_range(0, 99);
				if (sel < 75)
					len = $urandom_range(0, 6);
				else if (sel < 88)
					len = $urandom_range(7, SFC_MAX_PAYLOAD - 1);
				else if (sel < 96)
					len = SFC_MAX_PAYLOAD;
				else
					len = $urandom_range(SFC_MAX_PAYLOAD + 1, 255);
				q.push_back(live.hdr_byte);
				q.push_back(live.main_device_id);
				q.push_back(8'($urandom));
				q.push_back(live.data_func_code);
				q.push_back(8'(len));
				repeat ((len <= SFC_MAX_PAYLOAD) ? len : 3)
					q.push_back(8'($urandom));
			end
			endcase
			seal(q);
			if (k == KIND_DATA && $urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3))
					q.push_back(8'($urandom));
			// broken frames: a flipped byte, a short buffer, or extra bytes
			if (pick < 22) begin
				spot = $urandom_range(0, q.size() - 1);
				q[spot] = q[spot] ^ 8'($urandom_range(1, 255));
			end else if (pick < 30) begin
				spot = $urandom_range(1, q.size() - 1);
				while (q.size() > spot)
					void'(q.pop_back());
			end else if (pick < 36) begin
				repeat ($urandom_range(1, 3))
					q.push_back(8'($urandom));
			end
			send_seq(q, k);
		end
	endtask

	initial begin
		byte_t     fq[$];
		cfg_regs_t setting;
		int        target;
		arst_n = 1'b0;
		calm = 1'b0;
		bytes_sent = 0;
		quiet_cycles = 0;
		rx.valid = 1'b0;
		rx.rx_byte = '0;
		rx.req_type = KIND_CMD;
		rx.buffer_last = 1'b0;
		verdict.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_HDR_BYTE;
		cfg.wdata = '0;
		live = '{RST_HDR_BYTE, RST_MAIN_DEVICE_ID, RST_COPY_DEVICE_ID, RST_TAIL_BYTE,
			RST_DATA_FUNC_CODE, RST_ACK_HDR_BYTE, RST_ACK_ID_BYTE, RST_ACK_MARKER};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames on the reset register values
		fq = '{live.hdr_byte, live.main_device_id, 8'h00, 8'hFF};
		seal(fq);
		send_seq(fq, KIND_CMD);
		fq = '{live.ack_hdr_byte, live.ack_id_byte, live.ack_marker, 8'h33, 8'hC4};
		seal(fq);
		send_seq(fq, KIND_ACK);
		fq = '{live.hdr_byte, live.main_device_id, 8'h5E, live.data_func_code, 8'd1, 8'hFF};
		seal(fq);
		fq.push_back(8'h81);
		send_seq(fq, KIND_DATA);
		fq = '{live.hdr_byte};
		send_seq(fq, KIND_BAD);
		fq = '{live.ack_hdr_byte};
		send_seq(fq, KIND_ACK);
		fq = '{live.hdr_byte, live.main_device_id, 8'h00, live.data_func_code,
			8'(SFC_MAX_PAYLOAD + 1)};
		send_seq(fq, KIND_DATA);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
			0: setting = '0;
			1: setting = '1;
			default: setting = cfg_regs_t'({$urandom, $urandom});
			endcase
			drain();
			load_regs(setting);
			calm = (ph == 3);
			target = bytes_sent + PHASE_BYTES;
			while (bytes_sent < target)
				send_random_buffer();
		end
		drain();
		repeat (4) @(posedge clk);

		if (errors == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: files.f
hdl/sfc_pkg.sv
hdl/sfc_if.sv
hdl/sfc_cfg_regs.sv
hdl/sfc_parser.sv
hdl/serial_frame_checker_bcc_core.sv
hdl/sfc_checker.sv
tb/serial_frame_checker_bcc_checker.sv
tb/serial_frame_checker_bcc_core_tb.sv
